>>> src/fqnp_pkg.sv
// Shared field widths, operation and status codes, and result type for the purge queue.
package fqnp_pkg;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Operation codes
   localparam logic [KIND_W-1:0] OP_ENQ   = 2'd0;
   localparam logic [KIND_W-1:0] OP_DEQ   = 2'd1;
   localparam logic [KIND_W-1:0] OP_PEEK  = 2'd2;
   localparam logic [KIND_W-1:0] OP_PURGE = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Data words returned without a stored entry
   localparam logic signed [DATA_W-1:0] DATA_NONE  = 32'sd0;
   localparam logic signed [DATA_W-1:0] DATA_EMPTY = -32'sd1;

   // One response
   typedef struct packed {
      logic signed [DATA_W-1:0]   data;
      logic        [STATUS_W-1:0] status;
      logic        [COUNT_W-1:0]  count;
   } rsp_type;

endpackage

>>> src/fqnp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fqnp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/fifo_queue_with_negative_purge_unit.sv
// Top level: bounded ring FIFO of signed words with a purge of negative entries.
//
// Request channel (req_valid, req_stall, req_kind, req_value) carries one operation:
// enqueue, dequeue, peek or purge negatives. The response channel (rsp_valid,
// rsp_stall, rsp_data, rsp_status, rsp_count) returns exactly one response per
// request, in order, from an output register.
// When the response is loaded into the output register:
//   enqueue, and any operation that finds the queue full or empty: loaded at the
//   accepting edge itself, so one request per cycle while the receiver keeps up
//   dequeue or peek of a stored word: in the next cycle (registered RAM read)
//   purge: once the walk has examined every held entry, with one RAM read and
//   at most one write per cycle through the single storage RAM.
// One request is in work at a time; req_stall is high while a request is in
// work and while the output register holds a response that the receiver stalls.
// A new request is taken in the cycle the pending response leaves.
// Synchronous active-high reset empties the queue (head, tail and count to zero)
// and drops any pending response; storage contents are not cleared.
module fifo_queue_with_negative_purge_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic        [fqnp_pkg::KIND_W-1:0]      req_kind,
   input  logic signed [fqnp_pkg::DATA_W-1:0]      req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fqnp_pkg::DATA_W-1:0]      rsp_data,
   output logic        [fqnp_pkg::STATUS_W-1:0]    rsp_status,
   output logic        [fqnp_pkg::COUNT_W-1:0]     rsp_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int FW   = $clog2(DEPTH + 1);
   localparam int CntW = fqnp_pkg::COUNT_W;
   localparam int DatW = fqnp_pkg::DATA_W;
   localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);
   localparam logic [FW-1:0] FullFill = FW'(DEPTH);

   // Sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_PURGE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [AW-1:0]     wr_ff, wr_in;
   logic [FW-1:0]     kept_ff, kept_in;
   logic [FW-1:0]     left_ff, left_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fqnp_pkg::rsp_type rsp_ff, rsp_in;

   logic              req_accept;
   logic              rsp_free;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DatW-1:0]   ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DatW-1:0]   ram_rd_data;

   // Advance a ring pointer with wrap at DEPTH
   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
      return (idx == LastIdx) ? '0 : idx + 1'b1;
   endfunction

   // Ring storage
   fqnp_ram #(
      .WIDTH (DatW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshake: take a request only when idle and the output slot is free
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      kept_in      = kept_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = tail_ff;
      ram_wr_data  = req_value;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  fqnp_pkg::OP_ENQ: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.data  = fqnp_pkg::DATA_NONE;
                     if (fill_ff == FullFill) begin
                        rsp_in.status = fqnp_pkg::ST_FULL;
                     end else begin
                        ram_wr_en     = 1'b1;
                        tail_in       = ring_next(tail_ff);
                        fill_in       = fill_ff + 1'b1;
                        rsp_in.status = fqnp_pkg::ST_OK;
                     end
                     rsp_in.count = CntW'(fill_in);
                  end
                  fqnp_pkg::OP_DEQ, fqnp_pkg::OP_PEEK: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.data   = fqnp_pkg::DATA_EMPTY;
                        rsp_in.status = fqnp_pkg::ST_EMPTY;
                        rsp_in.count  = CntW'(fill_ff);
                     end else begin
                        ram_rd_en = 1'b1;
                        state_in  = S_READ;
                        if (req_kind == fqnp_pkg::OP_DEQ) begin
                           head_in = ring_next(head_ff);
                           fill_in = fill_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     // Purge: nothing to walk in an empty queue
                     if (fill_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.data   = fqnp_pkg::DATA_NONE;
                        rsp_in.status = fqnp_pkg::ST_OK;
                        rsp_in.count  = CntW'(fill_ff);
                     end else begin
                        state_in = S_PURGE;
                        rd_in    = head_ff;
                        wr_in    = head_ff;
                        kept_in  = '0;
                        left_in  = fill_ff;
                     end
                  end
               endcase
            end
         end

         S_READ: begin
            // Deliver the word read at the old head
            rsp_valid_in  = 1'b1;
            rsp_in.data   = ram_rd_data;
            rsp_in.status = fqnp_pkg::ST_OK;
            rsp_in.count  = CntW'(fill_ff);
            state_in      = S_IDLE;
         end

         S_PURGE: begin
            // Issue the next read of the walk
            if (left_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_ff;
               rd_in       = ring_next(rd_ff);
               left_in     = left_ff - 1'b1;
               pend_in     = 1'b1;
            end
            // Keep a non-negative word by writing it back at the compaction pointer
            if (pend_ff && !ram_rd_data[DatW-1]) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_ff;
               ram_wr_data = ram_rd_data;
               wr_in       = ring_next(wr_ff);
               kept_in     = kept_ff + 1'b1;
            end
            // Finish after the last word has been examined
            if (pend_ff && (left_ff == '0)) begin
               fill_in       = kept_in;
               tail_in       = wr_in;
               rsp_valid_in  = 1'b1;
               rsp_in.data   = fqnp_pkg::DATA_NONE;
               rsp_in.status = fqnp_pkg::ST_OK;
               rsp_in.count  = CntW'(kept_in);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk pointers and response payload
   always_ff @(posedge clock) begin
      rd_ff   <= rd_in;
      wr_ff   <= wr_in;
      kept_ff <= kept_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff.data;
   assign rsp_status = rsp_ff.status;
   assign rsp_count  = rsp_ff.count;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the ring FIFO with purge of negative words.
module tb;

   localparam int DEPTH        = 16;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int KIND_W       = fqnp_pkg::KIND_W;
   localparam int DATA_W       = fqnp_pkg::DATA_W;
   localparam int STATUS_W     = fqnp_pkg::STATUS_W;
   localparam int COUNT_W      = fqnp_pkg::COUNT_W;
   localparam int RANDOM_ITEMS = 1820;
   localparam int CALM_ITEMS   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic        [KIND_W-1:0] kind;
      logic signed [DATA_W-1:0] value;
      int                       reps;
      bit                       fixed;
      fqnp_pkg::rsp_type        rsp;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic        [KIND_W-1:0]   req_kind = fqnp_pkg::OP_ENQ;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_data;
   logic        [STATUS_W-1:0] rsp_status;
   logic        [COUNT_W-1:0]  rsp_count;

   // Shadow copy of the queue
   logic signed [DATA_W-1:0] ring_mem [DEPTH];
   logic        [IDX_W-1:0]  ring_head = '0;
   logic        [IDX_W-1:0]  ring_tail = '0;
   logic        [COUNT_W-1:0] ring_fill = '0;

   fqnp_pkg::rsp_type pending_rsp [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      stall_left = 0;
   bit      random_phase = 1'b0;
   bit      calm = 1'b0;
   logic    hold_off = 1'b0;

   // Directed stimulus: empty cases, extremes, full queue, purge with and without negatives
   plan_row_type directed_plan [0:14] = '{
      '{fqnp_pkg::OP_DEQ,   32'sd0,       1,  1'b1,
        '{fqnp_pkg::DATA_EMPTY, fqnp_pkg::ST_EMPTY, 5'd0}},
      '{fqnp_pkg::OP_PEEK,  32'sd0,       1,  1'b1,
        '{fqnp_pkg::DATA_EMPTY, fqnp_pkg::ST_EMPTY, 5'd0}},
      '{fqnp_pkg::OP_PURGE, 32'sd0,       1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd0}},
      '{fqnp_pkg::OP_ENQ,   32'h7fffffff, 1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd1}},
      '{fqnp_pkg::OP_ENQ,   32'h80000000, 1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd2}},
      '{fqnp_pkg::OP_ENQ,   -32'sd1,      1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd3}},
      '{fqnp_pkg::OP_ENQ,   32'sd0,       1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd4}},
      '{fqnp_pkg::OP_PEEK,  32'sd0,       1,  1'b1,
        '{32'h7fffffff,         fqnp_pkg::ST_OK,    5'd4}},
      '{fqnp_pkg::OP_PURGE, 32'sd0,       1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd2}},
      '{fqnp_pkg::OP_DEQ,   32'sd0,       1,  1'b1,
        '{32'h7fffffff,         fqnp_pkg::ST_OK,    5'd1}},
      '{fqnp_pkg::OP_DEQ,   32'sd0,       1,  1'b1,
        '{32'sd0,               fqnp_pkg::ST_OK,    5'd0}},
      '{fqnp_pkg::OP_ENQ,   32'sd0,       16, 1'b0,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd0}},
      '{fqnp_pkg::OP_ENQ,   32'h12345678, 1,  1'b1,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_FULL,  5'd16}},
      '{fqnp_pkg::OP_PURGE, 32'sd0,       1,  1'b0,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd0}},
      '{fqnp_pkg::OP_PURGE, 32'sd0,       1,  1'b0,
        '{fqnp_pkg::DATA_NONE,  fqnp_pkg::ST_OK,    5'd0}}
   };

   fifo_queue_with_negative_purge_unit #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the shadow queue and return the response it yields;
   // index registers are IDX_W bits wide, so they wrap at DEPTH by themselves
   function automatic fqnp_pkg::rsp_type queue_apply(input logic [KIND_W-1:0] kind,
                                                     input logic signed [DATA_W-1:0] value);
      fqnp_pkg::rsp_type  r;
      logic [IDX_W-1:0]   rd;
      logic [IDX_W-1:0]   wr;
      logic [COUNT_W-1:0] kept;
      int                 k;
      r.data   = fqnp_pkg::DATA_NONE;
      r.status = fqnp_pkg::ST_OK;
      case (kind)
         fqnp_pkg::OP_ENQ: begin
            if (ring_fill == DEPTH) begin
               r.status = fqnp_pkg::ST_FULL;
            end else begin
               ring_mem[ring_tail] = value;
               ring_tail = ring_tail + 1'b1;
               ring_fill = ring_fill + 1'b1;
            end
         end
         fqnp_pkg::OP_DEQ, fqnp_pkg::OP_PEEK: begin
            if (ring_fill == 0) begin
               r.data   = fqnp_pkg::DATA_EMPTY;
               r.status = fqnp_pkg::ST_EMPTY;
            end else begin
               r.data = ring_mem[ring_head];
               if (kind == fqnp_pkg::OP_DEQ) begin
                  ring_head = ring_head + 1'b1;
                  ring_fill = ring_fill - 1'b1;
               end
            end
         end
         default: begin
            // compact non-negative words toward head, oldest first
            rd   = ring_head;
            wr   = ring_head;
            kept = '0;
            for (k = 0; k < ring_fill; k++) begin
               if (!ring_mem[rd][DATA_W-1]) begin
                  ring_mem[wr] = ring_mem[rd];
                  wr   = wr + 1'b1;
                  kept = kept + 1'b1;
               end
               rd = rd + 1'b1;
            end
            ring_fill = kept;
            ring_tail = wr;
         end
      endcase
      r.count = ring_fill;
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("MISMATCH @%0d: %s", cycle_count, what);
   endtask

   // Compare one accepted response with the oldest expectation
   task automatic check_response();
      fqnp_pkg::rsp_type want;
      if (pending_rsp.size() == 0) begin
         note_mismatch($sformatf("unexpected response data=%0d status=%0d count=%0d",
                                 rsp_data, rsp_status, rsp_count));
         return;
      end
      want = pending_rsp.pop_front();
      if (rsp_data !== want.data)
         note_mismatch($sformatf("data expected %0d actual %0d", want.data, rsp_data));
      if (rsp_status !== want.status)
         note_mismatch($sformatf("status expected %0d actual %0d", want.status, rsp_status));
      if (rsp_count !== want.count)
         note_mismatch($sformatf("count expected %0d actual %0d", want.count, rsp_count));
   endtask

   // Offer one request, hold it until accepted, then record its expected response
   task automatic issue_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value,
                                input bit fixed, input fqnp_pkg::rsp_type fixed_rsp);
      fqnp_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = queue_apply(kind, value);
      pending_rsp.push_back(fixed ? fixed_rsp : predicted);
   endtask

   // Drop valid for a random burst now and then
   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Operation mix depends on the phase: fill up, drain, or balanced
   function automatic logic [KIND_W-1:0] pick_kind(input int phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         0:       return roll < 65 ? fqnp_pkg::OP_ENQ  : roll < 80 ? fqnp_pkg::OP_DEQ :
                         roll < 91 ? fqnp_pkg::OP_PEEK : fqnp_pkg::OP_PURGE;
         1:       return roll < 20 ? fqnp_pkg::OP_ENQ  : roll < 75 ? fqnp_pkg::OP_DEQ :
                         roll < 90 ? fqnp_pkg::OP_PEEK : fqnp_pkg::OP_PURGE;
         default: return roll < 38 ? fqnp_pkg::OP_ENQ  : roll < 72 ? fqnp_pkg::OP_DEQ :
                         roll < 87 ? fqnp_pkg::OP_PEEK : fqnp_pkg::OP_PURGE;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h80000000;
         1:       return 32'h7fffffff;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return $urandom();
      endcase
   endfunction

   // Response side: check accepted responses and stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_response();
         if (stall_left > 0)
            stall_left--;
         else if (!calm && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 7);
         rsp_stall <= (stall_left > 0) || hold_off;
      end
   end

   // Long receiver hold-off so the output register stays occupied and the block stalls its input
   initial begin
      wait (random_phase);
      repeat ($urandom_range(50, 300)) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fifo_queue_with_negative_purge_unit verification failed");
         $finish;
      end
   end

   initial begin
      logic signed [DATA_W-1:0] word;
      fqnp_pkg::rsp_type        none;
      int                       phase;
      none = '{fqnp_pkg::DATA_NONE, fqnp_pkg::ST_OK, '0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; repeated rows alternate the sign of random words
      foreach (directed_plan[i]) begin
         for (int k = 0; k < directed_plan[i].reps; k++) begin
            word = directed_plan[i].value;
            if (directed_plan[i].reps > 1) begin
               word = $urandom();
               word[DATA_W-1] = k[0];
            end
            maybe_idle();
            issue_request(directed_plan[i].kind, word, directed_plan[i].fixed,
                          directed_plan[i].rsp);
         end
      end

      // Random requests in phases; no idling in the last stretch
      random_phase = 1'b1;
      phase = 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            phase = $urandom_range(0, 2);
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
         maybe_idle();
         issue_request(pick_kind(phase), pick_word(), 1'b0, none);
      end
      req_valid <= 1'b0;

      // Let every response arrive, then allow for stray ones
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("fifo_queue_with_negative_purge_unit verification clean");
      end else begin
         $display("fifo_queue_with_negative_purge_unit verification failed");
      end
      $finish;
   end

endmodule

>>> fifo_queue_with_negative_purge_unit.f
src/fqnp_pkg.sv
src/fqnp_ram.sv
src/fifo_queue_with_negative_purge_unit.sv
tb/sv/tb.sv
